[hw/rtl/value_histogram_with_mode_unit_defines.svh]
// Assertion macros used by the histogram unit top level.
`ifndef VALUE_HISTOGRAM_WITH_MODE_UNIT_DEFINES_SVH
`define VALUE_HISTOGRAM_WITH_MODE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define VHIST_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never occurs outside reset.
`define VHIST_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VHIST_CHECK(label, prop, msg)
`define VHIST_NEVER(label, cond, msg)
`endif

`endif

[hw/rtl/vhist_pkg.sv]
// Types and constants of the value histogram unit.
package vhist_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int COUNT_BITS    = 16;
    localparam int KEY_W         = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    // Value travelling down the chain of cells.
    typedef struct packed {
        logic             valid;
        logic             done;
        logic             fin;
        logic [KEY_W-1:0] value;
    } token_t;

    // Contents of one table cell.
    typedef struct packed {
        logic                  used;
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] cnt;
    } entry_t;

    // Control from the top level to every cell.
    typedef struct packed {
        logic shift;
    } cell_ctl_t;

endpackage

[hw/rtl/vhist_if.sv]
// Valid/ready channels of the value histogram unit.
interface vhist_in_if
    import vhist_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] value;
    logic                    final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface vhist_out_if
    import vhist_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] entry_value;
    logic [COUNT_BITS-1:0]   entry_count;
    logic signed [KEY_W-1:0] top_value;
    logic [COUNT_BITS-1:0]   top_count;
    logic signed [KEY_W-1:0] bottom_value;
    logic [COUNT_BITS-1:0]   bottom_count;
    logic                    table_overflow;
    logic                    run_end;

    modport source (output valid, output entry_value, output entry_count,
                    output top_value, output top_count, output bottom_value,
                    output bottom_count, output table_overflow, output run_end,
                    input ready);
    modport sink   (input valid, input entry_value, input entry_count,
                    input top_value, input top_count, input bottom_value,
                    input bottom_count, input table_overflow, input run_end,
                    output ready);
endinterface

[hw/rtl/vhist_cell.sv]
// One cell of the histogram chain: a table entry plus a token stage.
module vhist_cell
    import vhist_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  token_t    tok_in,
    output token_t    tok_out,
    input  entry_t    ent_in,
    output entry_t    ent_out
);

    logic                  used_reg;
    logic                  used_next;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      key_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    token_t                tok_reg;
    token_t                tok_next;
    logic                  live;
    logic                  hit;
    logic                  alloc;

    always_comb
    begin
        live  = tok_in.valid && !tok_in.done;
        hit   = live && used_reg && (key_reg == tok_in.value);
        alloc = live && !used_reg;

        used_next = used_reg;
        key_next  = key_reg;
        cnt_next  = cnt_reg;
        if (ctl.shift)
        begin
            // advance the table one place towards the output
            used_next = ent_in.used;
            key_next  = ent_in.key;
            cnt_next  = ent_in.cnt;
        end
        else if (alloc)
        begin
            used_next = 1'b1;
            key_next  = tok_in.value;
            cnt_next  = COUNT_ONE;
        end
        else if (hit && (cnt_reg != COUNT_MAX))
        begin
            cnt_next = cnt_reg + COUNT_ONE;
        end

        tok_next       = tok_in;
        tok_next.done  = tok_in.done | hit | alloc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        cnt_reg <= cnt_next;
    end

    assign tok_out      = tok_reg;
    assign ent_out.used = used_reg;
    assign ent_out.key  = key_reg;
    assign ent_out.cnt  = cnt_reg;

endmodule

[hw/rtl/value_histogram_with_mode_unit.sv]
// Top level of the value histogram unit with mode and antimode.
// Values are taken one per cycle and run down a chain of TABLE_ENTRIES cells; each cell either
// counts a value equal to its key or claims the value if it is still free, and a value that
// leaves the end of the chain unclaimed is dropped and flags table_overflow. Accepting an item
// with final_item set closes the set: input is held off while that item walks the chain, after
// which the table shifts out through cell 0 at one result per cycle of output readiness,
// first-seen order, top and bottom entries tracked on the way. Input reopens once the last
// result is in the output register. Counts saturate at 2^COUNT_BITS - 1.
`include "value_histogram_with_mode_unit_defines.svh"

module value_histogram_with_mode_unit
    import vhist_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    vhist_in_if.sink    in_ch,
    vhist_out_if.source out_ch
);

    token_t    tok   [TABLE_ENTRIES+1];
    entry_t    ent   [TABLE_ENTRIES+1];
    cell_ctl_t ctl;

    logic busy_reg;
    logic busy_next;
    logic emit_reg;
    logic emit_next;
    logic ovf_reg;
    logic ovf_next;
    logic first_reg;
    logic first_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic [KEY_W-1:0]      top_key_reg;
    logic [KEY_W-1:0]      top_key_next;
    logic [COUNT_BITS-1:0] top_cnt_reg;
    logic [COUNT_BITS-1:0] top_cnt_next;
    logic [KEY_W-1:0]      bot_key_reg;
    logic [KEY_W-1:0]      bot_key_next;
    logic [COUNT_BITS-1:0] bot_cnt_reg;
    logic [COUNT_BITS-1:0] bot_cnt_next;

    logic [KEY_W-1:0]      o_key_reg;
    logic [COUNT_BITS-1:0] o_cnt_reg;
    logic [KEY_W-1:0]      o_top_key_reg;
    logic [COUNT_BITS-1:0] o_top_cnt_reg;
    logic [KEY_W-1:0]      o_bot_key_reg;
    logic [COUNT_BITS-1:0] o_bot_cnt_reg;
    logic                  o_ovf_reg;
    logic                  o_end_reg;

    logic   accept;
    logic   load;
    logic   is_last;
    token_t tail;

    assign in_ch.ready = !busy_reg;
    assign accept      = in_ch.valid && !busy_reg;

    assign tok[0].valid = accept;
    assign tok[0].done  = 1'b0;
    assign tok[0].fin   = in_ch.final_item;
    assign tok[0].value = in_ch.value;

    // beyond the last cell the table reads as empty
    assign ent[TABLE_ENTRIES] = '0;

    assign load      = emit_reg && (!out_valid_reg || out_ch.ready);
    assign ctl.shift = load;
    assign is_last   = !ent[1].used;
    assign tail      = tok[TABLE_ENTRIES];

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        vhist_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .ent_in  (ent[i+1]),
            .ent_out (ent[i])
        );
    end

    always_comb
    begin
        busy_next      = busy_reg;
        emit_next      = emit_reg;
        ovf_next       = ovf_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        top_key_next   = top_key_reg;
        top_cnt_next   = top_cnt_reg;
        bot_key_next   = bot_key_reg;
        bot_cnt_next   = bot_cnt_reg;

        if (accept && in_ch.final_item)
            busy_next = 1'b1;

        if (tail.valid)
        begin
            // drop a value that found no free cell
            if (!tail.done)
                ovf_next = 1'b1;
            if (tail.fin)
                emit_next = 1'b1;
        end

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            if (first_reg || (ent[0].cnt > top_cnt_reg))
            begin
                top_key_next = ent[0].key;
                top_cnt_next = ent[0].cnt;
            end
            if (first_reg || (ent[0].cnt < bot_cnt_reg))
            begin
                bot_key_next = ent[0].key;
                bot_cnt_next = ent[0].cnt;
            end
            first_next = is_last;
            if (is_last)
            begin
                emit_next = 1'b0;
                busy_next = 1'b0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            emit_reg      <= emit_next;
            ovf_reg       <= ovf_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_key_reg <= top_key_next;
        top_cnt_reg <= top_cnt_next;
        bot_key_reg <= bot_key_next;
        bot_cnt_reg <= bot_cnt_next;
        if (load)
        begin
            o_key_reg <= ent[0].key;
            o_cnt_reg <= ent[0].cnt;
            o_end_reg <= is_last;
            if (is_last)
            begin
                o_top_key_reg <= top_key_next;
                o_top_cnt_reg <= top_cnt_next;
                o_bot_key_reg <= bot_key_next;
                o_bot_cnt_reg <= bot_cnt_next;
                o_ovf_reg     <= ovf_reg;
            end
            else
            begin
                o_top_key_reg <= '0;
                o_top_cnt_reg <= '0;
                o_bot_key_reg <= '0;
                o_bot_cnt_reg <= '0;
                o_ovf_reg     <= 1'b0;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.entry_value    = $signed(o_key_reg);
    assign out_ch.entry_count    = o_cnt_reg;
    assign out_ch.top_value      = $signed(o_top_key_reg);
    assign out_ch.top_count      = o_top_cnt_reg;
    assign out_ch.bottom_value   = $signed(o_bot_key_reg);
    assign out_ch.bottom_count   = o_bot_cnt_reg;
    assign out_ch.table_overflow = o_ovf_reg;
    assign out_ch.run_end        = o_end_reg;

    `VHIST_CHECK(a_emit_busy, emit_reg |-> busy_reg, "emission outside a closed set")
    `VHIST_CHECK(a_emit_head, emit_reg |-> ent[0].used, "emission with an empty head cell")
    `VHIST_NEVER(a_emit_token, emit_reg && tail.valid, "value in the chain during emission")
    `VHIST_CHECK(a_mid_zero, (out_valid_reg && !o_end_reg) |-> (o_top_cnt_reg == '0 && o_bot_cnt_reg == '0 && !o_ovf_reg), "summary fields set before the run end")
    `VHIST_CHECK(a_cnt_nonzero, out_valid_reg |-> (o_cnt_reg != '0), "result with a zero count")

endmodule

[test/value_histogram_with_mode_unit_tb.sv]
// Self-checking testbench of the value histogram unit with mode and antimode.
module value_histogram_with_mode_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vhist_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned RANDOM_ITEMS = 420;
    localparam int unsigned CALM_AFTER   = 370;

    typedef struct packed {
        logic [KEY_W-1:0]      entry_value;
        logic [COUNT_BITS-1:0] entry_count;
        logic [KEY_W-1:0]      top_value;
        logic [COUNT_BITS-1:0] top_count;
        logic [KEY_W-1:0]      bottom_value;
        logic [COUNT_BITS-1:0] bottom_count;
        logic                  table_overflow;
        logic                  run_end;
    } hist_entry_t;

    class hist_scoreboard;
        logic [KEY_W-1:0]      keys   [TABLE_ENTRIES];
        logic [COUNT_BITS-1:0] counts [TABLE_ENTRIES];
        int unsigned           used;
        bit                    dropped;
        hist_entry_t           expected_entries [$];
        int unsigned           errors;

        function new();
            used    = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        function void tally_value(logic [KEY_W-1:0] v);
            for (int i = 0; i < used; i++)
            begin
                if (keys[i] == v)
                begin
                    if (counts[i] != COUNT_MAX)
                        counts[i] = counts[i] + 1'b1;
                    return;
                end
            end
            if (used < TABLE_ENTRIES)
            begin
                keys[used]   = v;
                counts[used] = COUNT_ONE;
                used++;
            end
            else
                dropped = 1'b1;
        endfunction

        // Walk the table in first-seen order; strict compares keep ties on the earliest entry.
        function void close_set();
            int          top_idx;
            int          bot_idx;
            hist_entry_t e;
            top_idx = 0;
            bot_idx = 0;
            for (int i = 1; i < used; i++)
            begin
                if (counts[i] > counts[top_idx])
                    top_idx = i;
                if (counts[i] < counts[bot_idx])
                    bot_idx = i;
            end
            for (int i = 0; i < used; i++)
            begin
                e             = '0;
                e.entry_value = keys[i];
                e.entry_count = counts[i];
                if (i == used - 1)
                begin
                    e.top_value      = keys[top_idx];
                    e.top_count      = counts[top_idx];
                    e.bottom_value   = keys[bot_idx];
                    e.bottom_count   = counts[bot_idx];
                    e.table_overflow = dropped;
                    e.run_end        = 1'b1;
                end
                expected_entries.push_back(e);
            end
            used    = 0;
            dropped = 1'b0;
        endfunction

        function void note_value(logic [KEY_W-1:0] v, logic fin);
            tally_value(v);
            if (fin)
                close_set();
        endfunction

        function void compare_field(string name, logic [KEY_W-1:0] want_v,
                                    logic [KEY_W-1:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_entry(hist_entry_t got);
            hist_entry_t want;
            if (expected_entries.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual value %0h count %0h",
                         $time, got.entry_value, got.entry_count);
                return;
            end
            want = expected_entries.pop_front();
            compare_field("entry_value",    want.entry_value,    got.entry_value);
            compare_field("entry_count",    KEY_W'(want.entry_count),
                          KEY_W'(got.entry_count));
            compare_field("top_value",      want.top_value,      got.top_value);
            compare_field("top_count",      KEY_W'(want.top_count),
                          KEY_W'(got.top_count));
            compare_field("bottom_value",   want.bottom_value,   got.bottom_value);
            compare_field("bottom_count",   KEY_W'(want.bottom_count),
                          KEY_W'(got.bottom_count));
            compare_field("table_overflow", KEY_W'(want.table_overflow),
                          KEY_W'(got.table_overflow));
            compare_field("run_end",        KEY_W'(want.run_end),
                          KEY_W'(got.run_end));
        endfunction

        function int unsigned pending();
            return expected_entries.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vhist_in_if  in_ch ();
    vhist_out_if out_ch ();

    value_histogram_with_mode_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hist_scoreboard sb = new();

    bit          calm;
    int unsigned items_sent;
    int unsigned idle_cycles;
    int unsigned out_hold;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result side in bursts, starting none once the run has gone calm.
    always @(posedge clk)
    begin
        if (out_hold != 0)
        begin
            out_hold--;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            out_hold = $urandom_range(0, 17);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_monitor
        hist_entry_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.entry_value    = out_ch.entry_value;
            got.entry_count    = out_ch.entry_count;
            got.top_value      = out_ch.top_value;
            got.top_count      = out_ch.top_count;
            got.bottom_value   = out_ch.bottom_value;
            got.bottom_count   = out_ch.bottom_count;
            got.table_overflow = out_ch.table_overflow;
            got.run_end        = out_ch.run_end;
            sb.check_entry(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Hold valid across back-to-back transfers; drop it only for an idle burst.
    task automatic send_item(logic [KEY_W-1:0] v, logic fin);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= v;
        in_ch.final_item <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_value(v, fin);
        items_sent++;
    endtask

    // Most sets are short with few distinct values; some overrun the table.
    task automatic send_random_set();
        int unsigned      set_len;
        int unsigned      pool_len;
        logic [KEY_W-1:0] pool [$];
        if ($urandom_range(0, 4) == 0)
        begin
            set_len  = $urandom_range(20, 60);
            pool_len = $urandom_range(8, 40);
        end
        else
        begin
            set_len  = $urandom_range(1, 12);
            pool_len = $urandom_range(1, 6);
        end
        for (int i = 0; i < pool_len; i++)
        begin
            case ($urandom_range(0, 5))
                0:       pool.push_back(32'h8000_0000);
                1:       pool.push_back(32'h7fff_ffff);
                default: pool.push_back($urandom());
            endcase
        end
        for (int i = 0; i < set_len; i++)
            send_item(pool[$urandom_range(0, pool_len - 1)], i == set_len - 1);
    endtask

    initial
    begin : stimulus
        int unsigned      random_start;
        logic [KEY_W-1:0] base;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.final_item = 1'b0;
        out_ch.ready     = 1'b0;
        calm             = 1'b0;
        items_sent       = 0;
        idle_cycles      = 0;
        out_hold         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the value, with ties on both the highest and lowest count.
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'hffff_ffff, 1'b1);
        // A lone value is both the most and the least frequent.
        send_item(32'h0000_0005, 1'b1);
        send_item(32'h0000_0003, 1'b0);
        send_item(32'h0000_0009, 1'b0);
        send_item(32'h0000_0009, 1'b0);
        send_item(32'h0000_0003, 1'b1);

        // Fill the table, overrun it, keep counting held values, close on a dropped one.
        base = $urandom();
        for (int i = 0; i <= TABLE_ENTRIES; i++)
            send_item(base + i, 1'b0);
        send_item(base, 1'b0);
        send_item(base + TABLE_ENTRIES - 1, 1'b0);
        send_item(base + TABLE_ENTRIES + 7, 1'b1);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            calm = (items_sent - random_start) >= CALM_AFTER;
            send_random_set();
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
